/* rtl/dag_triangle_count_merge_top_macros.svh */
`ifndef DAG_TRIANGLE_COUNT_MERGE_TOP_MACROS_SVH
`define DAG_TRIANGLE_COUNT_MERGE_TOP_MACROS_SVH
// Assertion macros; they expect clk and arst_n in scope.
`define DTC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed");
`define DTC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed");
`endif

/* rtl/dtc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package dtc_pkg;
	localparam int MAX_NODES = 16384;
	localparam int MAX_EDGES = 65536;
	localparam int NODE_W    = 14;
	localparam int EIDX_W    = 16;
	localparam int ECNT_W    = 17;
	localparam int ROW_AW    = 15;
	localparam int TOT_W     = 40;
	localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};

	localparam logic [1:0] OP_ROW   = 2'd0;
	localparam logic [1:0] OP_EDGE  = 2'd1;
	localparam logic [1:0] OP_COUNT = 2'd2;

	typedef enum logic [1:0] {K_ROW, K_EDGE, K_COUNT} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [EIDX_W-1:0]   slot;
		logic [ECNT_W-1:0]   value;
		logic [NODE_W-1:0]   src;
		logic [NODE_W-1:0]   dst;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_EDGE, ST_ROWU, ST_ROWV, ST_BND, ST_MRD, ST_MCMP, ST_NEXT, ST_DONE
	} state_t;

	function automatic logic [ECNT_W-1:0] clamp_idx(input logic [ECNT_W-1:0] x);
		return (x > ECNT_W'(MAX_EDGES)) ? ECNT_W'(MAX_EDGES) : x;
	endfunction
endpackage
`default_nettype wire

/* rtl/dtc_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module dtc_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [1:0]            op,
	input  wire logic [15:0]           slot,
	input  wire logic [16:0]           offset_value,
	input  wire logic [13:0]           edge_src,
	input  wire logic [13:0]           edge_dst,
	input  wire logic [16:0]           edge_count,
	output logic                       q_valid,
	output dtc_pkg::cmd_t              q_cmd,
	input  wire logic                  q_take
);
	import dtc_pkg::*;

	cmd_t       fifo_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	cmd_t       cmd_w;
	logic       keep_w, enq_w, deq_w;

	always_comb begin
		cmd_w.slot  = slot;
		cmd_w.src   = edge_src;
		cmd_w.dst   = edge_dst;
		cmd_w.kind  = K_ROW;
		cmd_w.value = offset_value;
		keep_w      = 1'b0;
		case (op)
			OP_ROW: begin
				keep_w = (ECNT_W'(slot) <= ECNT_W'(MAX_NODES));
			end
			OP_EDGE: begin
				cmd_w.kind = K_EDGE;
				keep_w     = 1'b1;
			end
			OP_COUNT: begin
				cmd_w.kind  = K_COUNT;
				cmd_w.value = clamp_idx(edge_count);
				keep_w      = 1'b1;
			end
			default: keep_w = 1'b0;
		endcase
	end

	assign full    = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd   = fifo_q[rp_q];
	assign enq_w   = push && !full && keep_w;
	assign deq_w   = q_take && q_valid;

	always_ff @(posedge clk) begin
		if (enq_w) begin
			fifo_q[wp_q] <= cmd_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (enq_w) begin
				wp_q <= !wp_q;
			end
			if (deq_w) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(enq_w) - 2'(deq_w);
		end
	end
endmodule
`default_nettype wire

/* rtl/dtc_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module dtc_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_valid,
	input  dtc_pkg::cmd_t              q_cmd,
	output logic                       q_take,
	output logic                       empty,
	input  wire logic                  pop,
	output logic [39:0]                triangle_total,
	output logic                       saturated
);
	import dtc_pkg::*;

	logic [ECNT_W-1:0] row_mem [MAX_NODES+1];
	logic [NODE_W-1:0] src_mem [MAX_EDGES];
	logic [NODE_W-1:0] dst_mem [MAX_EDGES];

	state_t            state_q, state_d;
	logic [ROW_AW-1:0] row_ra, row_rb;
	logic [EIDX_W-1:0] e_ra, e_rb;
	logic [ECNT_W-1:0] row_rd_a, row_rd_b;
	logic [NODE_W-1:0] src_rd, dst_rd_a, dst_rd_b;
	logic              row_we, edge_we, start, load_res;
	logic [ECNT_W-1:0] i_q, n_q, a_q, ae_q, b_q, be_q;
	logic [ECNT_W-1:0] lo_w, hi_w, na_w, nb_w;
	logic [NODE_W-1:0] v_q;
	logic [TOT_W-1:0]  total_q, res_total_q;
	logic              sat_q, res_sat_q, res_valid_q;

	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[q_cmd.slot[ROW_AW-1:0]] <= q_cmd.value;
		end
		row_rd_a <= row_mem[row_ra];
		row_rd_b <= row_mem[row_rb];
	end

	always_ff @(posedge clk) begin
		if (edge_we) begin
			src_mem[q_cmd.slot] <= q_cmd.src;
			dst_mem[q_cmd.slot] <= q_cmd.dst;
		end
		src_rd   <= src_mem[e_ra];
		dst_rd_a <= dst_mem[e_ra];
		dst_rd_b <= dst_mem[e_rb];
	end

	always_comb begin
		lo_w = clamp_idx(row_rd_a);
		hi_w = clamp_idx(row_rd_b);
		if (hi_w < lo_w) begin
			hi_w = lo_w;
		end
		na_w = a_q + ECNT_W'(dst_rd_a <= dst_rd_b);
		nb_w = b_q + ECNT_W'(dst_rd_a >= dst_rd_b);
	end

	always_comb begin
		state_d  = state_q;
		q_take   = 1'b0;
		row_we   = 1'b0;
		edge_we  = 1'b0;
		start    = 1'b0;
		load_res = 1'b0;
		row_ra   = {1'b0, src_rd};
		row_rb   = ROW_AW'(src_rd) + ROW_AW'(1);
		e_ra     = i_q[EIDX_W-1:0];
		e_rb     = b_q[EIDX_W-1:0];
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_take = 1'b1;
					case (q_cmd.kind)
						K_ROW:   row_we = 1'b1;
						K_EDGE:  edge_we = 1'b1;
						K_COUNT: begin
							start   = 1'b1;
							state_d = (q_cmd.value == '0) ? ST_DONE : ST_EDGE;
						end
						default: q_take = 1'b1;
					endcase
				end
			end
			ST_EDGE: state_d = ST_ROWU;
			ST_ROWU: state_d = ST_ROWV;
			ST_ROWV: begin
				row_ra  = {1'b0, v_q};
				row_rb  = ROW_AW'(v_q) + ROW_AW'(1);
				state_d = ST_BND;
			end
			ST_BND: begin
				state_d = (a_q < ae_q && lo_w < hi_w) ? ST_MRD : ST_NEXT;
			end
			ST_MRD: begin
				e_ra    = a_q[EIDX_W-1:0];
				state_d = ST_MCMP;
			end
			ST_MCMP: begin
				state_d = (na_w < ae_q && nb_w < be_q) ? ST_MRD : ST_NEXT;
			end
			ST_NEXT: begin
				state_d = (i_q + ECNT_W'(1) < n_q) ? ST_EDGE : ST_DONE;
			end
			ST_DONE: begin
				if (!res_valid_q || pop) begin
					load_res = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: n_q <= q_cmd.value;
			ST_ROWU: v_q <= dst_rd_a;
			ST_ROWV: begin
				a_q  <= lo_w;
				ae_q <= hi_w;
			end
			ST_BND: begin
				b_q  <= lo_w;
				be_q <= hi_w;
			end
			ST_MCMP: begin
				a_q <= na_w;
				b_q <= nb_w;
			end
			default: v_q <= v_q;
		endcase
		if (load_res) begin
			res_total_q <= total_q;
			res_sat_q   <= sat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			total_q     <= '0;
			sat_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				i_q     <= '0;
				total_q <= '0;
				sat_q   <= 1'b0;
			end
			if (state_q == ST_NEXT) begin
				i_q <= i_q + ECNT_W'(1);
			end
			if (state_q == ST_MCMP && dst_rd_a == dst_rd_b) begin
				if (total_q == TOTAL_MAX) begin
					sat_q <= 1'b1;
				end else begin
					total_q <= total_q + TOT_W'(1);
				end
			end
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign empty          = !res_valid_q;
	assign triangle_total = res_total_q;
	assign saturated      = res_sat_q;
endmodule
`default_nettype wire

/* rtl/dag_triangle_count_merge_top.sv */
// Load beats (row offset, edge) are taken one per cycle through a two-deep queue
// while it is not full. A count steps each edge through EDGE, ROWU, ROWV, BND and
// NEXT, each merge step through MRD and MCMP; they share two destination read ports.
// After the walk the result enters the output register once it is free or popped.
// Reset is asynchronous and active low; it empties the queue and result register
// and idles the sequencer. The graph stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module dag_triangle_count_merge_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  op,
	input  wire logic [15:0] slot,
	input  wire logic [16:0] offset_value,
	input  wire logic [13:0] edge_src,
	input  wire logic [13:0] edge_dst,
	input  wire logic [16:0] edge_count,
	output logic             empty,
	input  wire logic        pop,
	output logic [39:0]      triangle_total,
	output logic             saturated
);
	import dtc_pkg::*;

	logic q_valid, q_take;
	cmd_t q_cmd;

	dtc_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .op(op), .slot(slot),
		.offset_value(offset_value), .edge_src(edge_src), .edge_dst(edge_dst),
		.edge_count(edge_count), .q_valid(q_valid), .q_cmd(q_cmd), .q_take(q_take)
	);

	dtc_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_cmd(q_cmd), .q_take(q_take),
		.empty(empty), .pop(pop), .triangle_total(triangle_total), .saturated(saturated)
	);
endmodule
`default_nettype wire

/* rtl/dtc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "dag_triangle_count_merge_top_macros.svh"
module dtc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        empty,
	input wire logic        pop,
	input wire logic [39:0] triangle_total,
	input wire logic        saturated
);
	`DTC_ASSERT_NEXT(a_res_held, !empty && !pop, !empty && $stable(triangle_total))
	`DTC_ASSERT_NEXT(a_flag_held, !empty && !pop, $stable(saturated))
	`DTC_ASSERT_NOW(a_sat_max, !empty && saturated, triangle_total == 40'hFFFFFFFFFF)
endmodule

bind dag_triangle_count_merge_top dtc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop),
	.triangle_total(triangle_total), .saturated(saturated)
);
`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
	import dtc_pkg::*;

	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int IDLE_LIMIT = 2000000;
	localparam int HOLD_CYCLES = 2000;
	localparam int ITEM_TARGET = 1000;
	localparam int NODE_WIN = 16;
	localparam int EDGE_WIN = 32;
	localparam int TOP_EDGES = 4;

	class tri_scoreboard;
		typedef struct {
			logic [TOT_W-1:0] total;
			logic             sat;
		} tally_t;

		logic [ECNT_W-1:0] row_off[MAX_NODES+1];
		logic [NODE_W-1:0] e_src[MAX_EDGES];
		logic [NODE_W-1:0] e_dst[MAX_EDGES];
		tally_t            pending[$];
		int                errors;

		function void report(string msg);
			$display("MISMATCH at %0t: %s", $time, msg);
			errors++;
		endfunction

		function void list_span(longint unsigned n, output longint unsigned lo,
				output longint unsigned hi);
			if (n >= MAX_NODES) begin
				lo = 0;
				hi = 0;
				return;
			end
			lo = (row_off[n] > MAX_EDGES) ? MAX_EDGES : row_off[n];
			hi = (row_off[n+1] > MAX_EDGES) ? MAX_EDGES : row_off[n+1];
			if (hi < lo) hi = lo;
		endfunction

		function void note(logic [1:0] o, logic [15:0] s, logic [16:0] ov,
				logic [13:0] es, logic [13:0] ed, logic [16:0] ec);
			longint unsigned n, ua, ub, va, vb, c, sum;
			logic sat;
			tally_t t;
			case (o)
				OP_ROW: begin
					if (s <= MAX_NODES) row_off[s] = ov;
				end
				OP_EDGE: begin
					e_src[s] = es;
					e_dst[s] = ed;
				end
				OP_COUNT: begin
					n = (ec > MAX_EDGES) ? MAX_EDGES : ec;
					sum = 0;
					sat = 1'b0;
					for (longint unsigned i = 0; i < n; i++) begin
						list_span(e_src[i], ua, ub);
						list_span(e_dst[i], va, vb);
						c = 0;
						while (ua < ub && va < vb) begin
							if (e_dst[ua] == e_dst[va]) begin
								c++;
								ua++;
								va++;
							end else if (e_dst[ua] < e_dst[va]) begin
								ua++;
							end else begin
								va++;
							end
						end
						if (c > TOTAL_MAX - sum) begin
							sum = TOTAL_MAX;
							sat = 1'b1;
						end else begin
							sum += c;
						end
					end
					t.total = TOT_W'(sum);
					t.sat = sat;
					pending.push_back(t);
				end
				default: ;
			endcase
		endfunction

		function void check(logic [TOT_W-1:0] total, logic sat);
			tally_t t;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result total=%0d", total));
				return;
			end
			t = pending.pop_front();
			if (total !== t.total)
				report($sformatf("triangle_total %0d, expected %0d", total, t.total));
			if (sat !== t.sat)
				report($sformatf("saturated %0b, expected %0b", sat, t.sat));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [1:0]  op;
	logic [15:0] slot;
	logic [16:0] offset_value;
	logic [13:0] edge_src;
	logic [13:0] edge_dst;
	logic [16:0] edge_count;
	logic        empty;
	logic        pop;
	logic [39:0] triangle_total;
	logic        saturated;

	tri_scoreboard sb;
	logic          hold_req;
	int            idle_cycles;
	int            beats_sent;

	dag_triangle_count_merge_top u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .op(op), .slot(slot),
		.offset_value(offset_value), .edge_src(edge_src), .edge_dst(edge_dst),
		.edge_count(edge_count), .empty(empty), .pop(pop),
		.triangle_total(triangle_total), .saturated(saturated)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [13:0] pick_node();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 14'(MAX_NODES - 1 - $urandom_range(0, 1));
		return 14'($urandom_range(0, NODE_WIN - 1));
	endfunction

	function automatic logic [15:0] pick_edge_slot();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 16'(MAX_EDGES - TOP_EDGES + $urandom_range(0, TOP_EDGES - 1));
		return 16'($urandom_range(0, EDGE_WIN - 1));
	endfunction

	task automatic send_beat(logic [1:0] o, logic [15:0] s, logic [16:0] ov,
			logic [13:0] es, logic [13:0] ed, logic [16:0] ec, bit no_gap = 0);
		int gap;
		int r;
		r = $urandom_range(0, 99);
		gap = (no_gap || r < 60) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		op <= o;
		slot <= s;
		offset_value <= ov;
		edge_src <= es;
		edge_dst <= ed;
		edge_count <= ec;
		do @(posedge clk); while (full);
		sb.note(o, s, ov, es, ed, ec);
		beats_sent++;
	endtask

	task automatic send_graph();
		int nn, base, e, r;
		int start[10];
		bit unsorted, inverted;
		nn = $urandom_range(2, 8);
		base = $urandom_range(0, NODE_WIN - nn);
		r = $urandom_range(0, 99);
		unsorted = (r < 8);
		inverted = (r >= 8 && r < 14);
		e = 0;
		for (int k = 0; k < nn; k++) begin
			start[k] = e;
			for (int j = 0; j < nn - k - 1; j++) begin
				int v;
				v = unsorted ? nn - 1 - j : k + 1 + j;
				if ($urandom_range(0, 2) != 0) begin
					send_beat(OP_EDGE, 16'(e), 17'($urandom), 14'(base + k), 14'(base + v),
						17'($urandom));
					e++;
				end
			end
		end
		start[nn] = e;
		for (int k = 0; k <= nn; k++) begin
			if (inverted && $urandom_range(0, 3) == 0)
				send_beat(OP_ROW, 16'(base + k), 17'($urandom_range(0, e + 3)),
					14'($urandom), 14'($urandom), 17'($urandom));
			else
				send_beat(OP_ROW, 16'(base + k), 17'(start[k]), 14'($urandom),
					14'($urandom), 17'($urandom));
		end
		send_beat(OP_COUNT, 16'($urandom), 17'($urandom), 14'($urandom), 14'($urandom),
			17'(($urandom_range(0, 4) == 0) ? e + $urandom_range(0, 3) : e));
	endtask

	task automatic send_noise();
		int r;
		logic [1:0] o;
		o = 2'($urandom_range(0, 3));
		r = $urandom_range(0, 9);
		case (o)
			OP_ROW: begin
				if (r < 6)
					send_beat(OP_ROW, 16'($urandom_range(0, NODE_WIN)),
						17'($urandom_range(0, EDGE_WIN)), 14'($urandom), 14'($urandom),
						17'($urandom));
				else if (r < 8)
					send_beat(OP_ROW, 16'(MAX_NODES - 2 + $urandom_range(0, 2)),
						17'($urandom_range(MAX_EDGES - TOP_EDGES, 131071)), 14'($urandom),
						14'($urandom), 17'($urandom));
				else
					send_beat(OP_ROW, 16'($urandom_range(MAX_NODES + 1, 65535)),
						17'($urandom), 14'($urandom), 14'($urandom), 17'($urandom));
			end
			OP_EDGE: begin
				send_beat(OP_EDGE, pick_edge_slot(), 17'($urandom), pick_node(), pick_node(),
					17'($urandom));
			end
			OP_COUNT: begin
				send_beat(OP_COUNT, 16'($urandom), 17'($urandom), 14'($urandom),
					14'($urandom), 17'($urandom_range(0, EDGE_WIN)));
			end
			default: begin
				send_beat(OP_NONE, 16'($urandom), 17'($urandom), 14'($urandom),
					14'($urandom), 17'($urandom));
			end
		endcase
	endtask

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int stall;
		bit held;
		stall = 0;
		held = 0;
		pop <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) sb.check(triangle_total, saturated);
			if (hold_req && !held) begin
				held = 1;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (stall > 0) begin
				stall--;
				pop <= 1'b0;
			end else if ($urandom_range(0, 99) < 25) begin
				stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		sb = new();
		hold_req = 1'b0;
		idle_cycles = 0;
		beats_sent = 0;
		arst_n <= 1'b0;
		push <= 1'b0;
		op <= OP_ROW;
		slot <= '0;
		offset_value <= '0;
		edge_src <= '0;
		edge_dst <= '0;
		edge_count <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every entry that a later walk can reach is written once before it is read.
		for (int i = 0; i <= NODE_WIN; i++) send_beat(OP_ROW, 16'(i), '0, '0, '0, '0, 1);
		for (int i = MAX_NODES - 2; i <= MAX_NODES; i++)
			send_beat(OP_ROW, 16'(i), 17'(MAX_EDGES), '0, '0, '0, 1);
		for (int i = 0; i < EDGE_WIN; i++) send_beat(OP_EDGE, 16'(i), '0, '0, '0, '0, 1);
		for (int i = MAX_EDGES - TOP_EDGES; i < MAX_EDGES; i++)
			send_beat(OP_EDGE, 16'(i), '0, '0, '0, '0, 1);

		send_beat(OP_COUNT, 16'hFFFF, '0, '0, '0, 17'(EDGE_WIN));
		send_beat(OP_COUNT, '0, '0, '0, '0, '0);
		send_beat(OP_ROW, 16'(MAX_NODES), 17'h10000, '0, '0, '0);
		send_beat(OP_ROW, 16'(MAX_NODES - 1), 17'h1FFFF, 14'h3FFF, 14'h3FFF, 17'h1FFFF);
		send_beat(OP_ROW, 16'hFFFF, 17'd5, '0, '0, '0);
		send_beat(OP_ROW, 16'(MAX_NODES + 1), 17'd7, '0, '0, '0);
		send_beat(OP_EDGE, 16'hFFFF, 17'h1FFFF, 14'h3FFF, 14'h3FFF, '0);
		send_beat(OP_NONE, 16'hFFFF, 17'h1FFFF, 14'h3FFF, 14'h3FFF, 17'h1FFFF);
		send_beat(OP_EDGE, 16'(MAX_EDGES - 4), '0, 14'(MAX_NODES - 2), 14'd1, '0);
		send_beat(OP_EDGE, 16'(MAX_EDGES - 3), '0, 14'(MAX_NODES - 2), 14'd2, '0);
		send_beat(OP_EDGE, 16'(MAX_EDGES - 2), '0, 14'(MAX_NODES - 2), 14'h3FFF, '0);
		send_beat(OP_ROW, 16'(MAX_NODES - 2), 17'(MAX_EDGES - 4), '0, '0, '0);
		send_beat(OP_ROW, 16'(MAX_NODES - 1), 17'(MAX_EDGES - 1), '0, '0, '0);
		send_beat(OP_ROW, 16'(MAX_NODES), 17'h1FFFF, '0, '0, '0);
		send_beat(OP_ROW, 16'd0, 17'd0, '0, '0, '0);
		send_beat(OP_ROW, 16'd1, 17'd2, '0, '0, '0);
		send_beat(OP_ROW, 16'd2, 17'd3, '0, '0, '0);
		send_beat(OP_ROW, 16'd3, 17'd3, '0, '0, '0);
		send_beat(OP_EDGE, 16'd0, '0, 14'd0, 14'd1, '0);
		send_beat(OP_EDGE, 16'd1, '0, 14'd0, 14'd2, '0);
		send_beat(OP_EDGE, 16'd2, '0, 14'd1, 14'd2, '0);
		send_beat(OP_COUNT, '0, '0, '0, '0, 17'd3);
		send_beat(OP_EDGE, 16'd3, '0, 14'(MAX_NODES - 1), 14'd0, '0);
		send_beat(OP_ROW, 16'd5, 17'd10, '0, '0, '0);
		send_beat(OP_ROW, 16'd6, 17'd3, '0, '0, '0);
		send_beat(OP_EDGE, 16'd4, '0, 14'd5, 14'd0, '0);
		send_beat(OP_EDGE, 16'd5, '0, 14'(MAX_NODES - 2), 14'(MAX_NODES - 1), '0);
		send_beat(OP_COUNT, '0, '0, '0, '0, 17'd6);

		hold_req = 1'b1;
		while (beats_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 4) == 0)
				send_noise();
			else
				send_graph();
		end
		push <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

/* dag_triangle_count_merge_top.f */
+incdir+rtl
rtl/dtc_pkg.sv
rtl/dtc_front.sv
rtl/dtc_back.sv
rtl/dag_triangle_count_merge_top.sv
rtl/dtc_checker.sv
tb/sv/testbench.sv
